// ----- src/isam_pkg.sv -----
// Shared constants for the interval-scheduled audio mute core.
`timescale 1ns / 1ps

package isam_pkg;

    localparam int ENTRIES_DEF     = 8;
    localparam int TIME_BITS_DEF   = 40;
    localparam int SAMPLE_BITS_DEF = 32;

    // Request field widths
    localparam int IDX_W    = 3;
    localparam int TIME_W   = 40;
    localparam int SAMPLE_W = 32;

    // Input tdata layout, lowest bit first
    localparam int IDX_LSB    = 0;
    localparam int START_LSB  = IDX_LSB + IDX_W;
    localparam int END_LSB    = START_LSB + TIME_W;
    localparam int MODE_LSB   = END_LSB + TIME_W;
    localparam int SAMPLE_LSB = MODE_LSB + 1;
    localparam int IN_FIELDS_W = SAMPLE_LSB + SAMPLE_W;
    localparam int IN_DATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // Slot compare width, covers the largest table
    localparam int SLOT_W = 7;

    // Action codes carried on s_axis_tuser
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

endpackage

// ----- src/interval_scheduled_audio_mute_core.sv -----
// Interval-scheduled audio mute core: interval table scan and sample gate.
`timescale 1ns / 1ps

// Each sample request is passed through or zeroed when the frame time plus one
// (saturating) lies inside a valid mute interval of the table. The table lives
// in one synchronous RAM with a single read port; a sample request walks all
// ENTRIES slots one per cycle, retiring entries that have ended, and passes
// through accept, scan and result steps; the result step waits while the output
// register is still full. A load request writes one slot. A finished result
// waits in the output register while the next request is accepted. Frame time
// advances after a sample with tlast set and saturates at its top value.
module interval_scheduled_audio_mute_core
    import isam_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // entry_index, start_time, end_time, mute_mode, sample, zero fill
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // action
    input  logic [0:0]           s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // sample_out
    output logic [SAMPLE_W-1:0]  m_axis_tdata,
    // muted
    output logic [0:0]           m_axis_tuser
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int ENT_W  = 2 * TIME_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [TIME_BITS-1:0]   frame_reg, frame_next;
    logic [TIME_BITS-1:0]   t_reg, t_next;
    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                   hit_reg, hit_next;
    logic                   last_reg, last_next;
    logic [SAMPLE_W-1:0]    smp_reg, smp_next;
    logic                   out_vld_reg, out_vld_next;
    logic [SAMPLE_W-1:0]    out_data_reg, out_data_next;
    logic                   out_mute_reg, out_mute_next;

    logic [ENT_W-1:0]       mem [0:ENTRIES-1];
    logic [ENT_W-1:0]       rd_data_reg;

    logic                   accept;
    logic                   is_load;
    logic [SLOT_W-1:0]      slot_wide;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ENT_W-1:0]       wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [TIME_BITS-1:0]   ent_start;
    logic [TIME_BITS-1:0]   ent_end;
    logic                   ent_mute;
    logic                   ent_ended;
    logic                   ent_hit;
    logic [TIME_BITS-1:0]   t_calc;
    logic [SAMPLE_W-1:0]    smp_ext;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_load       = (s_axis_tuser[0] == ACT_LOAD);

    assign slot_wide = SLOT_W'(s_axis_tdata[IDX_LSB +: IDX_W]);
    assign wr_en     = accept && is_load && (slot_wide < SLOT_W'(ENTRIES));
    assign wr_addr   = slot_wide[ADDR_W-1:0];
    assign wr_data   = {s_axis_tdata[MODE_LSB],
                        TIME_BITS'(s_axis_tdata[END_LSB +: TIME_W]),
                        TIME_BITS'(s_axis_tdata[START_LSB +: TIME_W])};

    assign rd_en   = (state_reg == ST_SCAN) && (issue_reg < CNT_W'(ENTRIES));
    assign rd_addr = issue_reg[ADDR_W-1:0];

    assign ent_start = rd_data_reg[TIME_BITS-1:0];
    assign ent_end   = rd_data_reg[2*TIME_BITS-1:TIME_BITS];
    assign ent_mute  = rd_data_reg[ENT_W-1];
    assign ent_ended = ent_end < t_reg;
    assign ent_hit   = valid_reg[chk_idx_reg] && !ent_ended && ent_mute
                       && (ent_start <= t_reg);

    assign t_calc  = (frame_reg == {TIME_BITS{1'b1}}) ? frame_reg : frame_reg + 1'b1;
    assign smp_ext = SAMPLE_W'(signed'(s_axis_tdata[SAMPLE_LSB +: SAMPLE_BITS]));

    // Table RAM, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        frame_next    = frame_reg;
        t_next        = t_reg;
        issue_next    = issue_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        hit_next      = hit_reg;
        last_next     = last_reg;
        smp_next      = smp_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        out_mute_next = out_mute_reg;

        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_load)
                    begin
                        if (wr_en)
                        begin
                            valid_next[wr_addr] = 1'b1;
                        end
                    end
                    else
                    begin
                        t_next     = t_calc;
                        issue_next = '0;
                        hit_next   = 1'b0;
                        last_next  = s_axis_tlast;
                        smp_next   = smp_ext;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_addr;
                    issue_next   = issue_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (valid_reg[chk_idx_reg] && ent_ended)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                    end
                    hit_next = hit_reg || ent_hit;
                    if (chk_idx_reg == ADDR_W'(ENTRIES - 1))
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = hit_reg ? '0 : smp_reg;
                    out_mute_next = hit_reg;
                    if (last_reg)
                    begin
                        frame_next = t_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            frame_reg   <= '0;
            issue_reg   <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            frame_reg   <= frame_next;
            issue_reg   <= issue_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        chk_idx_reg  <= chk_idx_next;
        hit_reg      <= hit_next;
        last_reg     <= last_next;
        smp_reg      <= smp_next;
        out_data_reg <= out_data_next;
        out_mute_reg <= out_mute_next;
    end

    assign m_axis_tvalid   = out_vld_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_mute_reg;

endmodule
